// File: hw/rtl/htfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 step shared by the sensor frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam int unsigned FRAME_LAST = 6;
    localparam int unsigned OFFSET_W   = 15;
    localparam int unsigned RAW_W      = 20;
    localparam int unsigned CENTI_W    = 16;
    localparam int unsigned HUM_Q_W    = 14;
    localparam int unsigned TEMP_Q_W   = 15;

    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [2:0]  POS_LAST   = 3'(FRAME_LAST);

    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_SCALE = 15'd20000;
    localparam logic signed [CENTI_W-1:0] TEMP_BIAS = 16'sd5000;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_ALL_ZERO = 2'd1,
        ERR_CRC      = 2'd2
    } error_code_t;

    typedef enum logic [0:0] {
        REG_HUMIDITY_OFFSET    = 1'b0,
        REG_TEMPERATURE_OFFSET = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        error_code_t      error_code;
        logic [7:0]       status;
        logic [RAW_W-1:0] humidity_raw;
        logic [RAW_W-1:0] temperature_raw;
    } frame_rec_t;

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } frame_push_t;

    typedef struct packed {
        logic       valid;
        frame_rec_t rec;
    } frame_head_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/humidity_temp_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes the seven-byte reply of a humidity and temperature sensor.
//
// Input channel (s_*): one reply byte per item; s_frame_start marks byte 0
// and drops any partial frame. After seven bytes the position wraps on its
// own. Bytes 0..5 run through CRC-8 (poly 0x31, init 0xFF) checked against
// byte 6.
// Result channel (m_*): one item per frame, registered through the queue and
// the two conversion stages: status, 20-bit raw values, values in
// hundredths with offsets added, and an error code (all-zero before CRC).
// Throughput: one byte per cycle, set by the combinational CRC-8 step in
// the intake. A frame-record queue (FIFO_DEPTH entries) and two registered
// conversion stages let the intake keep taking bytes while the receiver
// stalls; s_ready drops only when the queue is full.
// Configuration: cfg_we writes cfg_wdata into the offset chosen by cfg_addr
// (0 humidity, 1 temperature); write only while idle.
// Reset: frame position 0, CRC 0xFF, offsets 0, queue and outputs empty.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
    import htfd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_addr,
    input  wire logic [OFFSET_W-1:0]    cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_rx_byte,
    input  wire logic                   s_frame_start,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_error_code,
    output logic [7:0]                  m_sensor_status,
    output logic [RAW_W-1:0]            m_humidity_raw,
    output logic [RAW_W-1:0]            m_temperature_raw,
    output logic signed [CENTI_W-1:0]   m_humidity_centi,
    output logic signed [CENTI_W-1:0]   m_temperature_centi
);

    logic signed [OFFSET_W-1:0] hum_off_reg, hum_off_next;
    logic signed [OFFSET_W-1:0] temp_off_reg, temp_off_next;

    frame_push_t q_wr;
    frame_head_t q_head;
    logic        q_full;
    logic        q_pop;

    always_comb begin
        hum_off_next  = hum_off_reg;
        temp_off_next = temp_off_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_HUMIDITY_OFFSET:    hum_off_next  = signed'(cfg_wdata);
                REG_TEMPERATURE_OFFSET: temp_off_next = signed'(cfg_wdata);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_off_reg  <= '0;
            temp_off_reg <= '0;
        end else begin
            hum_off_reg  <= hum_off_next;
            temp_off_reg <= temp_off_next;
        end
    end

    htfd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_frame_start (s_frame_start),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    htfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .full    (q_full),
        .head    (q_head),
        .pop     (q_pop)
    );

    htfd_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .head                (q_head),
        .pop                 (q_pop),
        .humidity_offset     (hum_off_reg),
        .temperature_offset  (temp_off_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_error_code        (m_error_code),
        .m_sensor_status     (m_sensor_status),
        .m_humidity_raw      (m_humidity_raw),
        .m_temperature_raw   (m_temperature_raw),
        .m_humidity_centi    (m_humidity_centi),
        .m_temperature_centi (m_temperature_centi)
    );

endmodule
`default_nettype wire

// File: hw/rtl/htfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_front
// Byte intake: frame position, running CRC-8, all-zero tracking and frame
// assembly. Pushes one frame record into the queue when it takes the checksum byte.
// ----------------------------------------------------------------------------
module htfd_front
    import htfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_frame_start,
    input  wire logic        q_full,
    output frame_push_t      q_wr
);

    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       zero_reg, zero_next;
    logic [7:0] fb_reg [0:FRAME_LAST-1];

    logic       accept;
    logic [2:0] pos_eff;
    logic [7:0] crc_eff;
    logic       zero_eff;
    logic       last_byte;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign pos_eff   = s_frame_start ? 3'd0 : pos_reg;
    assign crc_eff   = s_frame_start ? CRC_INIT : crc_reg;
    assign zero_eff  = s_frame_start ? 1'b1 : zero_reg;
    assign last_byte = (pos_eff == POS_LAST);

    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        zero_next = zero_reg;
        if (accept) begin
            if (last_byte) begin
                pos_next  = 3'd0;
                crc_next  = CRC_INIT;
                zero_next = 1'b1;
            end else begin
                pos_next  = pos_eff + 3'd1;
                crc_next  = crc8_byte(crc_eff, s_rx_byte);
                zero_next = zero_eff && (s_rx_byte == 8'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 3'd0;
            crc_reg  <= CRC_INIT;
            zero_reg <= 1'b1;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            zero_reg <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !last_byte) begin
            fb_reg[pos_eff] <= s_rx_byte;
        end
    end

    always_comb begin
        q_wr.push                = accept && last_byte;
        q_wr.rec.status          = fb_reg[0];
        q_wr.rec.humidity_raw    = {fb_reg[1], fb_reg[2], fb_reg[3][7:4]};
        q_wr.rec.temperature_raw = {fb_reg[3][3:0], fb_reg[4], fb_reg[5]};
        priority if (zero_reg && (s_rx_byte == 8'd0)) begin
            q_wr.rec.error_code = ERR_ALL_ZERO;
        end else if (crc_reg != s_rx_byte) begin
            q_wr.rec.error_code = ERR_CRC;
        end else begin
            q_wr.rec.error_code = ERR_OK;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("frame position out of range");

    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |=> (pos_reg == 3'd0) && (crc_reg == CRC_INIT) && zero_reg)
        else $error("frame state not restarted after checksum byte");

endmodule
`default_nettype wire

// File: hw/rtl/htfd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_fifo
// Short frame-record queue between the byte intake and the conversion path.
// ----------------------------------------------------------------------------
module htfd_fifo
    import htfd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire frame_push_t wr,
    output logic             full,
    output frame_head_t      head,
    input  wire logic        pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_rec_t       mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head.valid = (cnt_reg != '0);
    assign head.rec   = mem_reg[rd_ptr_reg];
    assign do_push    = wr.push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr.rec;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> !full)
        else $error("frame record pushed into full queue");

endmodule
`default_nettype wire

// File: hw/rtl/htfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_back
// Conversion path: scale raw values to hundredths, add bias and offsets,
// and hold the result item in the output register.
// ----------------------------------------------------------------------------
module htfd_back
    import htfd_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire frame_head_t                 head,
    output logic                             pop,
    input  wire logic signed [OFFSET_W-1:0]  humidity_offset,
    input  wire logic signed [OFFSET_W-1:0]  temperature_offset,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_error_code,
    output logic [7:0]                       m_sensor_status,
    output logic [RAW_W-1:0]                 m_humidity_raw,
    output logic [RAW_W-1:0]                 m_temperature_raw,
    output logic signed [CENTI_W-1:0]        m_humidity_centi,
    output logic signed [CENTI_W-1:0]        m_temperature_centi
);

    logic                   s1_valid_reg, s1_valid_next;
    frame_rec_t             s1_rec_reg;
    logic [HUM_Q_W-1:0]     s1_h_reg;
    logic [TEMP_Q_W-1:0]    s1_t_reg;
    logic                   out_valid_reg, out_valid_next;
    frame_rec_t             out_rec_reg;
    logic signed [CENTI_W-1:0] out_h_reg;
    logic signed [CENTI_W-1:0] out_t_reg;

    logic                   out_load;
    logic                   s1_load;
    logic [33:0]            h_prod;
    logic [34:0]            t_prod;
    logic signed [CENTI_W-1:0] h_sum;
    logic signed [CENTI_W-1:0] t_sum;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s1_load  = head.valid && (!s1_valid_reg || out_load);
    assign pop      = s1_load;

    assign h_prod = 34'(head.rec.humidity_raw) * 34'(HUM_SCALE);
    assign t_prod = 35'(head.rec.temperature_raw) * 35'(TEMP_SCALE);

    assign h_sum = signed'({2'b00, s1_h_reg}) + CENTI_W'(humidity_offset);
    assign t_sum = signed'({1'b0, s1_t_reg}) - TEMP_BIAS + CENTI_W'(temperature_offset);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_rec_reg <= head.rec;
            s1_h_reg   <= h_prod[33:20];
            s1_t_reg   <= t_prod[34:20];
        end
        if (out_load) begin
            out_rec_reg <= s1_rec_reg;
            out_h_reg   <= h_sum;
            out_t_reg   <= t_sum;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_error_code        = out_rec_reg.error_code;
    assign m_sensor_status     = out_rec_reg.status;
    assign m_humidity_raw      = out_rec_reg.humidity_raw;
    assign m_temperature_raw   = out_rec_reg.temperature_raw;
    assign m_humidity_centi    = out_h_reg;
    assign m_temperature_centi = out_t_reg;

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_load) |=> s1_valid_reg && $stable(s1_rec_reg))
        else $error("stalled conversion stage lost its item");

    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid && (!s1_valid_reg || out_load))
        else $error("queue popped without room in conversion stage");

endmodule
`default_nettype wire
